// ===== sv/prism_support_volume_accumulator_macros.svh =====
// Assertion macros shared by the prism support volume accumulator RTL
`ifndef PRISM_SUPPORT_VOLUME_ACCUMULATOR_MACROS_SVH
`define PRISM_SUPPORT_VOLUME_ACCUMULATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PSVA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PSVA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/psva_pkg.sv =====
// Types, constants and the microcode table of the prism support volume accumulator
`timescale 1ns / 1ps

package psva_pkg;

	// field widths
	localparam int COORD_W = 20;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int NRM_W   = 16;
	localparam int COS_W   = 15;
	localparam int VOL_W   = 63;
	localparam int NET_W   = 64;
	localparam int IDX_W   = 3;

	// internal value widths
	localparam int NCMP_W  = 44;   // face normal component
	localparam int DN_W    = 60;   // N . n
	localparam int SH_W    = 40;   // sum of |h|
	localparam int L2_W    = 88;   // |N|^2
	localparam int C2_W    = 30;   // cos^2, full 15-bit cosine
	localparam int LIMB_W  = 33;   // signed multiplier operand
	localparam int PROD_W  = 2 * LIMB_W;
	localparam int ACC_W   = 128;
	localparam int VOL_SHIFT = 44;
	localparam int QNUM_W  = 60;   // shifted volume numerator

	// divide by six, one hex digit per cycle
	localparam int DIG_W     = 4;
	localparam int NUM_DIGS  = QNUM_W / DIG_W;
	localparam int DCNT_W    = 4;
	localparam int RECIP6    = 43;
	localparam int RECIP6_SH = 8;

	// microcode
	localparam int STEP_W   = 6;
	localparam int NUM_OPS  = 45;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_OPS - 1);

	typedef enum logic [IDX_W-1:0] {
		CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z,
		CFG_NORMAL_X, CFG_NORMAL_Y, CFG_NORMAL_Z,
		CFG_COS_CRIT, CFG_REF_VOL
	} cfg_idx_t;

	typedef enum logic [5:0] {
		OP_E1X, OP_E1Y, OP_E1Z, OP_E2X, OP_E2Y, OP_E2Z,
		OP_DAX, OP_DAY, OP_DAZ, OP_DBX, OP_DBY, OP_DBZ, OP_DCX, OP_DCY, OP_DCZ,
		OP_PNX, OP_PNY, OP_PNZ,
		OP_NXL, OP_NXH, OP_NYL, OP_NYH, OP_NZL, OP_NZH,
		OP_DNL, OP_DNH, OP_SHL, OP_SHH,
		OP_COS, OP_C2, OP_L2L0, OP_L2L1, OP_L2L2
	} opnd_t;

	typedef enum logic [2:0] {
		WR_NONE, WR_NX, WR_NY, WR_NZ, WR_SH, WR_DN, WR_C2, WR_VOL
	} dest_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RUN, S_DRAIN, S_UPDATE, S_FIN, S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] sh;    // partial product offset in 32-bit limbs
		logic       neg;
		logic       clr;   // start a new sum
	} mac_ctl_t;

	typedef struct packed {
		opnd_t    a;
		opnd_t    b;
		mac_ctl_t mc;
		dest_t    wr;
	} uop_t;

	typedef struct packed {
		logic ready;
		logic issue;
		uop_t uop;
		logic update;
		logic fin;
		logic load;
	} seq_ctl_t;

	typedef logic [VOL_W-1:0] vol_t;

	function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] p,
		input logic signed [COORD_W-1:0] q);
		return {p[COORD_W-1], p} - {q[COORD_W-1], q};
	endfunction

	// saturating add at 2^63-1
	function automatic vol_t sat_add(input vol_t t, input vol_t v);
		logic [VOL_W:0] s;
		s = {1'b0, t} + {1'b0, v};
		return s[VOL_W] ? {VOL_W{1'b1}} : s[VOL_W-1:0];
	endfunction

	function automatic uop_t mk(input opnd_t a, input opnd_t b, input logic [1:0] sh,
		input logic neg, input logic clr, input dest_t wr);
		uop_t u;
		u.a = a;
		u.b = b;
		u.mc.sh = sh;
		u.mc.neg = neg;
		u.mc.clr = clr;
		u.wr = wr;
		return u;
	endfunction

	// one multiply-accumulate per step
	function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			// face normal N = e1 x e2
			6'd0:  u = mk(OP_E1Y, OP_E2Z, 2'd0, 1'b0, 1'b1, WR_NONE);
			6'd1:  u = mk(OP_E1Z, OP_E2Y, 2'd0, 1'b1, 1'b0, WR_NX);
			6'd2:  u = mk(OP_E1Z, OP_E2X, 2'd0, 1'b0, 1'b1, WR_NONE);
			6'd3:  u = mk(OP_E1X, OP_E2Z, 2'd0, 1'b1, 1'b0, WR_NY);
			6'd4:  u = mk(OP_E1X, OP_E2Y, 2'd0, 1'b0, 1'b1, WR_NONE);
			6'd5:  u = mk(OP_E1Y, OP_E2X, 2'd0, 1'b1, 1'b0, WR_NZ);
			// vertex heights over the plane
			6'd6:  u = mk(OP_DAX, OP_PNX, 2'd0, 1'b0, 1'b1, WR_NONE);
			6'd7:  u = mk(OP_DAY, OP_PNY, 2'd0, 1'b0, 1'b0, WR_NONE);
			6'd8:  u = mk(OP_DAZ, OP_PNZ, 2'd0, 1'b0, 1'b0, WR_SH);
			6'd9:  u = mk(OP_DBX, OP_PNX, 2'd0, 1'b0, 1'b1, WR_NONE);
			6'd10: u = mk(OP_DBY, OP_PNY, 2'd0, 1'b0, 1'b0, WR_NONE);
			6'd11: u = mk(OP_DBZ, OP_PNZ, 2'd0, 1'b0, 1'b0, WR_SH);
			6'd12: u = mk(OP_DCX, OP_PNX, 2'd0, 1'b0, 1'b1, WR_NONE);
			6'd13: u = mk(OP_DCY, OP_PNY, 2'd0, 1'b0, 1'b0, WR_NONE);
			6'd14: u = mk(OP_DCZ, OP_PNZ, 2'd0, 1'b0, 1'b0, WR_SH);
			// N . n
			6'd15: u = mk(OP_NXL, OP_PNX, 2'd0, 1'b0, 1'b1, WR_NONE);
			6'd16: u = mk(OP_NXH, OP_PNX, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd17: u = mk(OP_NYL, OP_PNY, 2'd0, 1'b0, 1'b0, WR_NONE);
			6'd18: u = mk(OP_NYH, OP_PNY, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd19: u = mk(OP_NZL, OP_PNZ, 2'd0, 1'b0, 1'b0, WR_NONE);
			6'd20: u = mk(OP_NZH, OP_PNZ, 2'd1, 1'b0, 1'b0, WR_DN);
			// cos^2
			6'd21: u = mk(OP_COS, OP_COS, 2'd0, 1'b0, 1'b1, WR_C2);
			// volume numerator (N . n) * sum|h|
			6'd22: u = mk(OP_DNL, OP_SHL, 2'd0, 1'b0, 1'b1, WR_NONE);
			6'd23: u = mk(OP_DNL, OP_SHH, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd24: u = mk(OP_DNH, OP_SHL, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd25: u = mk(OP_DNH, OP_SHH, 2'd2, 1'b0, 1'b0, WR_VOL);
			// |N|^2
			6'd26: u = mk(OP_NXL, OP_NXL, 2'd0, 1'b0, 1'b1, WR_NONE);
			6'd27: u = mk(OP_NXL, OP_NXH, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd28: u = mk(OP_NXH, OP_NXL, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd29: u = mk(OP_NXH, OP_NXH, 2'd2, 1'b0, 1'b0, WR_NONE);
			6'd30: u = mk(OP_NYL, OP_NYL, 2'd0, 1'b0, 1'b0, WR_NONE);
			6'd31: u = mk(OP_NYL, OP_NYH, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd32: u = mk(OP_NYH, OP_NYL, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd33: u = mk(OP_NYH, OP_NYH, 2'd2, 1'b0, 1'b0, WR_NONE);
			6'd34: u = mk(OP_NZL, OP_NZL, 2'd0, 1'b0, 1'b0, WR_NONE);
			6'd35: u = mk(OP_NZL, OP_NZH, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd36: u = mk(OP_NZH, OP_NZL, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd37: u = mk(OP_NZH, OP_NZH, 2'd2, 1'b0, 1'b0, WR_NONE);
			// steep test: cos^2 |N|^2 - (N . n)^2, sign read after the last step
			6'd38: u = mk(OP_DNL, OP_DNL, 2'd0, 1'b1, 1'b1, WR_NONE);
			6'd39: u = mk(OP_DNL, OP_DNH, 2'd1, 1'b1, 1'b0, WR_NONE);
			6'd40: u = mk(OP_DNH, OP_DNL, 2'd1, 1'b1, 1'b0, WR_NONE);
			6'd41: u = mk(OP_DNH, OP_DNH, 2'd2, 1'b1, 1'b0, WR_NONE);
			6'd42: u = mk(OP_C2, OP_L2L0, 2'd0, 1'b0, 1'b0, WR_NONE);
			6'd43: u = mk(OP_C2, OP_L2L1, 2'd1, 1'b0, 1'b0, WR_NONE);
			6'd44: u = mk(OP_C2, OP_L2L2, 2'd2, 1'b0, 1'b0, WR_NONE);
			default: u = mk(OP_COS, OP_COS, 2'd0, 1'b0, 1'b1, WR_NONE);
		endcase
		return u;
	endfunction

endpackage

// ===== sv/psva_mac.sv =====
// Shared 33x33 signed multiplier with a 128-bit shifted accumulator
`timescale 1ns / 1ps

module psva_mac import psva_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     issue,
	input  mac_ctl_t                 ctl,
	input  logic signed [LIMB_W-1:0] a,
	input  logic signed [LIMB_W-1:0] b,
	output logic                     vld_s1,
	output logic signed [ACC_W-1:0]  acc_next,
	output logic signed [ACC_W-1:0]  acc_q
);

	logic signed [PROD_W-1:0] prod_s1;
	mac_ctl_t                 ctl_s1;
	logic signed [ACC_W-1:0]  ext;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  base;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= a * b;
			ctl_s1  <= ctl;
		end
	end

	// place the partial product and add or subtract
	always_comb begin
		ext = {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		case (ctl_s1.sh)
			2'd1:    term = ext <<< 32;
			2'd2:    term = ext <<< 64;
			default: term = ext;
		endcase
		base = ctl_s1.clr ? '0 : acc_q;
		acc_next = base + (term ^ {ACC_W{ctl_s1.neg}}) + ACC_W'(ctl_s1.neg);
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= acc_next;
		end
	end

endmodule

// ===== sv/psva_div6.sv =====
// Divide by six, one hex digit per cycle, most significant digit first
`timescale 1ns / 1ps

module psva_div6 import psva_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [QNUM_W-1:0] num,
	output logic              busy,
	output logic [QNUM_W-1:0] quo
);

	logic [QNUM_W-1:0] num_q;
	logic [QNUM_W-1:0] quo_q;
	logic [2:0]        rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;

	logic [6:0]        cur;
	logic [11:0]       scaled;
	logic [DIG_W-1:0]  qd;
	logic [2:0]        rem_d;

	// digit step: cur < 96, reciprocal 43/256 is exact for that range
	always_comb begin
		cur    = {rem_q, num_q[QNUM_W-1 -: DIG_W]};
		scaled = {5'b0, cur} * 12'(RECIP6);
		qd     = scaled[RECIP6_SH +: DIG_W];
		rem_d  = 3'(cur - ({3'b0, qd} << 2) - ({3'b0, qd} << 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= rem_d;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DCNT_W'(NUM_DIGS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << DIG_W;
			quo_q <= {quo_q[QNUM_W-DIG_W-1:0], qd};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== sv/psva_seq.sv =====
// Sequencer: steps the microcode through the shared multiplier per triangle
`timescale 1ns / 1ps

module psva_seq import psva_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     tri_valid,
	input  logic     last_item,
	input  logic     div_busy,
	input  logic     out_free,
	output seq_ctl_t ctl
);

	state_t              state_q, state_d;
	logic [STEP_W-1:0]   step_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (tri_valid) state_d = S_RUN;
			S_RUN:    if (step_q == LAST_STEP) state_d = S_DRAIN;
			S_DRAIN:  if (!div_busy) state_d = S_UPDATE;
			S_UPDATE: state_d = last_item ? S_FIN : S_IDLE;
			S_FIN:    state_d = S_OUT;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl.ready  = (state_q == S_IDLE);
		ctl.issue  = (state_q == S_RUN);
		ctl.uop    = uop_rom(step_q);
		ctl.update = (state_q == S_UPDATE);
		ctl.fin    = (state_q == S_FIN);
		ctl.load   = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RUN) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

endmodule

// ===== sv/prism_support_volume_accumulator.sv =====
// Top level: prism volume per triangle against one base plane, three saturating totals
// A triangle is accepted in the idle cycle, then runs 45 multiply-accumulate steps through
// one shared 33x33 multiplier, a drain that waits for the divider and an update state.
// A last triangle adds a finish state and an output state that waits for a free output
// register; its result then waits there while the following triangles are taken.
// arst_n clears the totals, the error flag, the sequencer and the output valid; plane
// registers reset to origin 0, normal (0,0,1), cosine 0, reference 0.
`timescale 1ns / 1ps
`include "prism_support_volume_accumulator_macros.svh"

module prism_support_volume_accumulator import psva_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [VOL_W-1:0]          cfg_data,
	// triangle channel
	input  logic                      tri_valid,
	output logic                      tri_ready,
	input  logic signed [COORD_W-1:0] vertex_a_x,
	input  logic signed [COORD_W-1:0] vertex_a_y,
	input  logic signed [COORD_W-1:0] vertex_a_z,
	input  logic signed [COORD_W-1:0] vertex_b_x,
	input  logic signed [COORD_W-1:0] vertex_b_y,
	input  logic signed [COORD_W-1:0] vertex_b_z,
	input  logic signed [COORD_W-1:0] vertex_c_x,
	input  logic signed [COORD_W-1:0] vertex_c_y,
	input  logic signed [COORD_W-1:0] vertex_c_z,
	input  logic                      face_visible,
	input  logic                      last_triangle,
	// result channel
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [VOL_W-1:0]          downward_volume,
	output logic [VOL_W-1:0]          upward_volume,
	output logic [VOL_W-1:0]          visible_steep_volume,
	output logic signed [NET_W-1:0]   net_volume,
	output logic signed [NET_W-1:0]   support_volume,
	output logic                      degenerate_seen
);

	// plane registers
	logic signed [COORD_W-1:0] org_x_q, org_y_q, org_z_q;
	logic signed [NRM_W-1:0]   pn_x_q, pn_y_q, pn_z_q;
	logic [COS_W-1:0]          cos_q;
	logic [VOL_W-1:0]          ref_q;

	// per-triangle operands
	logic signed [DIFF_W-1:0]  e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	logic signed [DIFF_W-1:0]  dax_q, day_q, daz_q, dbx_q, dby_q, dbz_q;
	logic signed [DIFF_W-1:0]  dcx_q, dcy_q, dcz_q;
	logic                      vis_q, last_q;

	// intermediate results
	logic signed [NCMP_W-1:0]  nx_q, ny_q, nz_q;
	logic signed [DN_W-1:0]    dn_q;
	logic [SH_W-1:0]           sh_q;
	logic [C2_W-1:0]           c2_q;
	logic [L2_W-1:0]           l2_q;
	dest_t                     wr_s1;
	logic                      sh_pend_q, vol_pend_q;

	// totals and result staging
	vol_t                      down_total_q, up_total_q, vis_total_q;
	logic                      degen_q;
	logic signed [NET_W-1:0]   net_q, diff_q;

	// output register
	logic                      res_valid_q;
	vol_t                      res_down_q, res_up_q, res_vis_q;
	logic signed [NET_W-1:0]   res_net_q, res_sup_q;
	logic                      res_degen_q;

	seq_ctl_t                  ctl;
	logic                      accept, out_free;
	logic signed [LIMB_W-1:0]  op_a, op_b;
	logic                      vld_s1;
	logic signed [ACC_W-1:0]   acc_next, acc_q, acc_abs;
	logic [SH_W-1:0]           h_w, h_abs;
	logic                      div_busy;
	logic [QNUM_W-1:0]         quo;
	vol_t                      vol;
	logic                      degen_now, steep_now;
	logic signed [NET_W:0]     sup_w;
	logic signed [NET_W-1:0]   sup_sat;

	assign accept   = tri_valid && ctl.ready;
	assign out_free = !res_valid_q || res_ready;
	assign tri_ready = ctl.ready;

	// operand select; low limbs unsigned, high limb signed for N and N . n, unsigned for sum|h| and |N|^2
	function automatic logic signed [LIMB_W-1:0] pick(input opnd_t o);
		logic signed [LIMB_W-1:0] r;
		case (o)
			OP_E1X:  r = LIMB_W'(e1x_q);
			OP_E1Y:  r = LIMB_W'(e1y_q);
			OP_E1Z:  r = LIMB_W'(e1z_q);
			OP_E2X:  r = LIMB_W'(e2x_q);
			OP_E2Y:  r = LIMB_W'(e2y_q);
			OP_E2Z:  r = LIMB_W'(e2z_q);
			OP_DAX:  r = LIMB_W'(dax_q);
			OP_DAY:  r = LIMB_W'(day_q);
			OP_DAZ:  r = LIMB_W'(daz_q);
			OP_DBX:  r = LIMB_W'(dbx_q);
			OP_DBY:  r = LIMB_W'(dby_q);
			OP_DBZ:  r = LIMB_W'(dbz_q);
			OP_DCX:  r = LIMB_W'(dcx_q);
			OP_DCY:  r = LIMB_W'(dcy_q);
			OP_DCZ:  r = LIMB_W'(dcz_q);
			OP_PNX:  r = LIMB_W'(pn_x_q);
			OP_PNY:  r = LIMB_W'(pn_y_q);
			OP_PNZ:  r = LIMB_W'(pn_z_q);
			OP_NXL:  r = {1'b0, nx_q[31:0]};
			OP_NXH:  r = LIMB_W'($signed(nx_q[NCMP_W-1:32]));
			OP_NYL:  r = {1'b0, ny_q[31:0]};
			OP_NYH:  r = LIMB_W'($signed(ny_q[NCMP_W-1:32]));
			OP_NZL:  r = {1'b0, nz_q[31:0]};
			OP_NZH:  r = LIMB_W'($signed(nz_q[NCMP_W-1:32]));
			OP_DNL:  r = {1'b0, dn_q[31:0]};
			OP_DNH:  r = LIMB_W'($signed(dn_q[DN_W-1:32]));
			OP_SHL:  r = {1'b0, sh_q[31:0]};
			OP_SHH:  r = {{(LIMB_W-SH_W+32){1'b0}}, sh_q[SH_W-1:32]};
			OP_COS:  r = {{(LIMB_W-COS_W){1'b0}}, cos_q};
			OP_C2:   r = {{(LIMB_W-C2_W){1'b0}}, c2_q};
			OP_L2L0: r = {1'b0, l2_q[31:0]};
			OP_L2L1: r = {1'b0, l2_q[63:32]};
			OP_L2L2: r = {{(LIMB_W-L2_W+64){1'b0}}, l2_q[L2_W-1:64]};
			default: r = '0;
		endcase
		return r;
	endfunction

	assign op_a = pick(ctl.uop.a);
	assign op_b = pick(ctl.uop.b);

	psva_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.tri_valid (tri_valid),
		.last_item (last_q),
		.div_busy  (div_busy),
		.out_free  (out_free),
		.ctl       (ctl)
	);

	psva_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (ctl.issue),
		.ctl      (ctl.uop.mc),
		.a        (op_a),
		.b        (op_b),
		.vld_s1   (vld_s1),
		.acc_next (acc_next),
		.acc_q    (acc_q)
	);

	// volume numerator |acc| >> 44 goes to the divider
	assign acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;

	psva_div6 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vol_pend_q),
		.num    (acc_abs[VOL_SHIFT +: QNUM_W]),
		.busy   (div_busy),
		.quo    (quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			pn_x_q  <= '0;
			pn_y_q  <= '0;
			pn_z_q  <= NRM_W'(16384);
			cos_q   <= '0;
			ref_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ORIGIN_X: org_x_q <= cfg_data[COORD_W-1:0];
				CFG_ORIGIN_Y: org_y_q <= cfg_data[COORD_W-1:0];
				CFG_ORIGIN_Z: org_z_q <= cfg_data[COORD_W-1:0];
				CFG_NORMAL_X: pn_x_q  <= cfg_data[NRM_W-1:0];
				CFG_NORMAL_Y: pn_y_q  <= cfg_data[NRM_W-1:0];
				CFG_NORMAL_Z: pn_z_q  <= cfg_data[NRM_W-1:0];
				CFG_COS_CRIT: cos_q   <= cfg_data[COS_W-1:0];
				CFG_REF_VOL:  ref_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the triangle: edge vectors and offsets from the plane origin
	always_ff @(posedge clk) begin
		if (accept) begin
			e1x_q  <= sdiff(vertex_b_x, vertex_a_x);
			e1y_q  <= sdiff(vertex_b_y, vertex_a_y);
			e1z_q  <= sdiff(vertex_b_z, vertex_a_z);
			e2x_q  <= sdiff(vertex_c_x, vertex_a_x);
			e2y_q  <= sdiff(vertex_c_y, vertex_a_y);
			e2z_q  <= sdiff(vertex_c_z, vertex_a_z);
			dax_q  <= sdiff(vertex_a_x, org_x_q);
			day_q  <= sdiff(vertex_a_y, org_y_q);
			daz_q  <= sdiff(vertex_a_z, org_z_q);
			dbx_q  <= sdiff(vertex_b_x, org_x_q);
			dby_q  <= sdiff(vertex_b_y, org_y_q);
			dbz_q  <= sdiff(vertex_b_z, org_z_q);
			dcx_q  <= sdiff(vertex_c_x, org_x_q);
			dcy_q  <= sdiff(vertex_c_y, org_y_q);
			dcz_q  <= sdiff(vertex_c_z, org_z_q);
			vis_q  <= face_visible;
			last_q <= last_triangle;
		end
	end

	// write-back of finished sums
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			case (wr_s1)
				WR_NX:   nx_q <= acc_next[NCMP_W-1:0];
				WR_NY:   ny_q <= acc_next[NCMP_W-1:0];
				WR_NZ:   nz_q <= acc_next[NCMP_W-1:0];
				WR_DN:   dn_q <= acc_next[DN_W-1:0];
				WR_C2:   c2_q <= acc_next[C2_W-1:0];
				default: ;
			endcase
		end
		// acc_q trails issue by the product and accumulator registers: it holds the full |N|^2 while step 39 issues
		if (ctl.issue && ctl.uop.a == OP_DNL && ctl.uop.b == OP_DNH) begin
			l2_q <= acc_q[L2_W-1:0];
		end
	end

	// sum of |h|, one height at a time from the registered sum
	assign h_w   = acc_q[SH_W-1:0];
	assign h_abs = h_w[SH_W-1] ? (~h_w + 1'b1) : h_w;

	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q <= '0;
		end else if (sh_pend_q) begin
			sh_q <= sh_q + h_abs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1      <= WR_NONE;
			sh_pend_q  <= 1'b0;
			vol_pend_q <= 1'b0;
		end else begin
			wr_s1      <= ctl.issue ? ctl.uop.wr : WR_NONE;
			sh_pend_q  <= vld_s1 && (wr_s1 == WR_SH);
			vol_pend_q <= vld_s1 && (wr_s1 == WR_VOL);
		end
	end

	// total update; the totals clear when a result is loaded
	assign vol       = VOL_W'(quo);
	assign degen_now = (nx_q == '0) && (ny_q == '0) && (nz_q == '0);
	assign steep_now = !acc_q[ACC_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_total_q <= '0;
			up_total_q   <= '0;
			vis_total_q  <= '0;
			degen_q      <= 1'b0;
		end else if (ctl.load) begin
			down_total_q <= '0;
			up_total_q   <= '0;
			vis_total_q  <= '0;
			degen_q      <= 1'b0;
		end else if (ctl.update) begin
			if (degen_now) begin
				degen_q <= 1'b1;
			end else if (dn_q[DN_W-1]) begin
				down_total_q <= sat_add(down_total_q, vol);
				if (vis_q && steep_now) begin
					vis_total_q <= sat_add(vis_total_q, vol);
				end
			end else begin
				up_total_q <= sat_add(up_total_q, vol);
			end
		end
	end

	// net and reference minus steep, then saturating support
	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			net_q  <= $signed({1'b0, down_total_q}) - $signed({1'b0, up_total_q});
			diff_q <= $signed({1'b0, ref_q}) - $signed({1'b0, vis_total_q});
		end
	end

	always_comb begin
		sup_w = {diff_q[NET_W-1], diff_q} - {net_q[NET_W-1], net_q};
		if (sup_w[NET_W] != sup_w[NET_W-1]) begin
			sup_sat = sup_w[NET_W] ? {1'b1, {(NET_W-1){1'b0}}} : {1'b0, {(NET_W-1){1'b1}}};
		end else begin
			sup_sat = sup_w[NET_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			res_down_q  <= down_total_q;
			res_up_q    <= up_total_q;
			res_vis_q   <= vis_total_q;
			res_net_q   <= net_q;
			res_sup_q   <= sup_sat;
			res_degen_q <= degen_q;
		end
	end

	assign res_valid            = res_valid_q;
	assign downward_volume      = res_down_q;
	assign upward_volume        = res_up_q;
	assign visible_steep_volume = res_vis_q;
	assign net_volume           = res_net_q;
	assign support_volume       = res_sup_q;
	assign degenerate_seen      = res_degen_q;

	`PSVA_ASSERT_IMP(a_ready_pipe_empty, ctl.ready, !vld_s1 && !div_busy, "accept with work in flight")
	`PSVA_ASSERT_IMP(a_update_div_done, ctl.update, !div_busy, "total update before quotient ready")
	`PSVA_ASSERT_IMP(a_load_when_free, ctl.load, !res_valid_q || res_ready, "result overwritten")
	`PSVA_ASSERT_NXT(a_load_clears, ctl.load, (down_total_q == '0) && !degen_q, "totals not cleared")

endmodule
